// File: sv/mpct_pkg.sv
// Package for the multi-press countdown timer.
// Widths, register indexes, reset values and shared structs; no dependencies.
package mpct_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned BtnW    = 3;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned SecW    = 20;
  localparam int unsigned MinW    = 15;
  localparam int unsigned SecShW  = 6;
  localparam int unsigned CntW    = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  localparam logic [SecW-1:0] SecondsMax   = '1;
  localparam logic [BtnW-1:0] CenterButton = 3'd1;
  localparam logic [CntW-1:0] CntSat       = 2'd3;

  localparam logic [CfgW-1:0] RstPressWindow = 16'd500;
  localparam logic [CfgW-1:0] RstTickPeriod  = 16'd1000;
  localparam logic [CfgW-1:0] RstSingleAdd   = 16'd60;
  localparam logic [CfgW-1:0] RstDoubleAdd   = 16'd600;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESS_WINDOW = 8'd0,
    REG_TICK_PERIOD  = 8'd1,
    REG_SINGLE_ADD   = 8'd2,
    REG_DOUBLE_ADD   = 8'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_POLL  = 1'b0,
    CMD_PRESS = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [CfgW-1:0] press_window;
    logic [CfgW-1:0] tick_period;
    logic [CfgW-1:0] single_add;
    logic [CfgW-1:0] double_add;
  } cfg_t;

  typedef struct packed {
    logic            handled;
    logic [SecW-1:0] secs;
    logic [CntW-1:0] pend;
  } core_res_t;

endpackage

// File: sv/mpct_cfg.sv
// Configuration register file of the countdown timer.
// Depends on mpct_pkg.
module mpct_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [mpct_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [mpct_pkg::CfgW-1:0]    wr_data_i,
  output mpct_pkg::cfg_t               cfg_o
);
  import mpct_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_PRESS_WINDOW: cfg_d.press_window = wr_data_i;
        REG_TICK_PERIOD:  cfg_d.tick_period  = wr_data_i;
        REG_SINGLE_ADD:   cfg_d.single_add   = wr_data_i;
        REG_DOUBLE_ADD:   cfg_d.double_add   = wr_data_i;
        default:          cfg_d = cfg_q; // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_window <= RstPressWindow;
      cfg_q.tick_period  <= RstTickPeriod;
      cfg_q.single_add   <= RstSingleAdd;
      cfg_q.double_add   <= RstDoubleAdd;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/mpct_core.sv
// Timer state and press-group decode; one item per cycle from the input register unless the result register stalls.
// Holds the timer state and the middle result register. Depends on mpct_pkg.
module mpct_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpct_pkg::cfg_t             cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       in_cmd_i,
  input  logic [mpct_pkg::BtnW-1:0]  in_btn_i,
  input  logic [mpct_pkg::TimeW-1:0] in_now_i,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output mpct_pkg::core_res_t        res_o
);
  import mpct_pkg::*;

  logic [SecW-1:0]  secs_q, secs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW-1:0] lpt_q, lpt_d;
  logic [TimeW-1:0] ltt_q, ltt_d;
  logic             vld_q;
  core_res_t        res_q, res_d;

  logic             fire;
  logic [TimeW-1:0] dp, dt;
  logic             in_win, tick_due, close_grp;
  logic [CfgW-1:0]  add;
  logic [SecW:0]    sum;
  logic [SecW-1:0]  applied, base;

  assign in_ready_o = !vld_q || res_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // group settlement: add per press count, three or more clears
  always_comb begin
    unique case (cnt_q)
      2'd1:    add = cfg_i.single_add;
      2'd2:    add = cfg_i.double_add;
      default: add = '0;
    endcase
    sum = {1'b0, secs_q} + {{(SecW + 1 - CfgW){1'b0}}, add};
    if (cnt_q == CntSat) begin
      applied = '0;
    end else if (sum[SecW]) begin
      applied = SecondsMax;
    end else begin
      applied = sum[SecW-1:0];
    end
  end

  always_comb begin
    dp        = in_now_i - lpt_q;
    dt        = in_now_i - ltt_q;
    in_win    = dp <= {{(TimeW - CfgW){1'b0}}, cfg_i.press_window};
    tick_due  = dt >= {{(TimeW - CfgW){1'b0}}, cfg_i.tick_period};
    close_grp = (cnt_q != '0) && !in_win;
    base      = close_grp ? applied : secs_q;

    secs_d = secs_q;
    cnt_d  = cnt_q;
    lpt_d  = lpt_q;
    ltt_d  = ltt_q;
    res_d  = res_q;

    if (fire) begin
      res_d.handled = 1'b1;
      if (cmd_e'(in_cmd_i) == CMD_PRESS) begin
        if (in_btn_i == CenterButton) begin
          if (in_win) begin
            cnt_d = (cnt_q == CntSat) ? CntSat : cnt_q + 2'd1;
          end else begin
            secs_d = applied;
            cnt_d  = 2'd1;
          end
          lpt_d = in_now_i;
        end else begin
          res_d.handled = 1'b0;
        end
      end else if (tick_due) begin
        if (close_grp) begin
          cnt_d = '0;
        end
        secs_d = (base != '0) ? base - 1'b1 : '0;
        ltt_d  = in_now_i;
      end
      res_d.secs = secs_d;
      res_d.pend = cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      secs_q <= '0;
      cnt_q  <= '0;
      lpt_q  <= '0;
      ltt_q  <= '0;
      vld_q  <= 1'b0;
    end else begin
      secs_q <= secs_d;
      cnt_q  <= cnt_d;
      lpt_q  <= lpt_d;
      ltt_q  <= ltt_d;
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: sv/mpct_disp.sv
// Output stage: splits remaining seconds into minutes and seconds and holds the result.
// Divide by 60 is a reciprocal multiply with one correction step. Depends on mpct_pkg.
module mpct_disp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mpct_pkg::core_res_t           in_res_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_handled_o,
  output logic [mpct_pkg::OutDataW-1:0] out_data_o
);
  import mpct_pkg::*;

  logic                vld_q;
  logic                hnd_q;
  logic [SecW-1:0]     secs_q;
  logic [MinW-1:0]     min_q, min_d;
  logic [SecShW-1:0]   sec_q, sec_d;
  logic [CntW-1:0]     pend_q;

  logic [SecW-3:0]     y;
  logic [SecW+13:0]    prod;
  logic [MinW-1:0]     q0;
  logic [SecW:0]       q60;
  logic [SecW:0]       rfull;
  logic [6:0]          r0;

  assign in_ready_o = !vld_q || out_ready_i;

  // x/60 = (x>>2)/15; 34952/2^19 undershoots 1/15 so q0 is the quotient or one less
  always_comb begin
    y     = in_res_i.secs[SecW-1:2];
    prod  = y * 16'd34952;
    q0    = prod[SecW+13:19];
    q60   = {q0, 6'd0} - {4'd0, q0, 2'd0};
    rfull = {1'b0, in_res_i.secs} - q60;
    r0    = rfull[6:0];
    if (r0 >= 7'd60) begin
      min_d = q0 + 1'b1;
      sec_d = SecShW'(r0 - 7'd60);
    end else begin
      min_d = q0;
      sec_d = r0[SecShW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hnd_q  <= in_res_i.handled;
      secs_q <= in_res_i.secs;
      min_q  <= min_d;
      sec_q  <= sec_d;
      pend_q <= in_res_i.pend;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_handled_o = hnd_q;
  assign out_data_o    = {5'd0, pend_q, sec_q, min_q, secs_q};

endmodule

// File: sv/multi_press_countdown_timer_top.sv
// Top level of the multi-press countdown timer: input register, core, display stage.
// Depends on mpct_pkg, mpct_cfg, mpct_core and mpct_disp.
//
// Channel  | Direction | Ports                       | Contents
// s_axis   | in        | tvalid/tready/tdata/tuser   | tdata: button_number, now_ms; tuser: command
// m_axis   | out       | tvalid/tready/tdata/tuser   | tdata: remaining/min/sec/pending; tuser: handled
// cfg      | in        | cfg_valid/ready/index/data  | register index and 16-bit value
//
// Three register stages: input, timer core, display; an accepted item passes through
// them in that order to m_axis. One transaction per cycle is sustained while m_axis
// is not stalled. The timer state updates as an item leaves the input register, so
// each item sees the state left by the one before. Reset clears state and config to
// defaults. A stall on m_axis fills the stages back to s_axis_tready.
module multi_press_countdown_timer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mpct_pkg::InDataW-1:0]      s_axis_tdata,  // [2:0] button_number, [34:3] now_ms
  input  logic                              s_axis_tuser,  // [0] command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [19:0] remaining_seconds, [34:20] minutes_shown, [40:35] seconds_shown,
  // [42:41] pending_presses
  output logic [mpct_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tuser,  // [0] handled
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mpct_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mpct_pkg::CfgW-1:0]         cfg_data_i
);
  import mpct_pkg::*;

  cfg_t             cfg;
  logic             in_vld_q;
  logic             in_cmd_q;
  logic [BtnW-1:0]  in_btn_q;
  logic [TimeW-1:0] in_now_q;
  logic             core_ready;
  logic             mid_valid, mid_ready;
  core_res_t        mid_res;

  assign cfg_ready_o = 1'b1;

  mpct_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  assign s_axis_tready = !in_vld_q || core_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= s_axis_tuser;
      in_btn_q <= s_axis_tdata[BtnW-1:0];
      in_now_q <= s_axis_tdata[BtnW+TimeW-1:BtnW];
    end
  end

  mpct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_vld_q),
    .in_ready_o  (core_ready),
    .in_cmd_i    (in_cmd_q),
    .in_btn_i    (in_btn_q),
    .in_now_i    (in_now_q),
    .res_valid_o (mid_valid),
    .res_ready_i (mid_ready),
    .res_o       (mid_res)
  );

  mpct_disp u_disp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (mid_valid),
    .in_ready_o    (mid_ready),
    .in_res_i      (mid_res),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_handled_o (m_axis_tuser),
    .out_data_o    (m_axis_tdata)
  );

  // seconds field always below a minute
  a_sec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[40:35] < 6'd60))
    else $error("seconds_shown out of range");

  // minutes and seconds recombine to the remaining count
  a_div_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ({6'd0, m_axis_tdata[34:20]} * 21'd60 + {15'd0, m_axis_tdata[40:35]}
       == {1'b0, m_axis_tdata[19:0]}))
    else $error("minutes/seconds split inconsistent");

  // input backpressure only ever comes from a stalled output
  a_stall_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output stall");

endmodule

// File: tb/sv/tb_multi_press_countdown_timer_top.sv
// Testbench for multi_press_countdown_timer_top: directed rows, some with fixed results,
// then random press and poll traffic under several register settings; all others are
// checked against a local timer model. Depends on mpct_pkg and the block's RTL.
module tb_multi_press_countdown_timer_top;
  import mpct_pkg::*;

  typedef struct packed {
    logic              handled;
    logic [SecW-1:0]   remaining;
    logic [MinW-1:0]   mins;
    logic [SecShW-1:0] secs;
    logic [CntW-1:0]   pend;
  } timer_res_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [BtnW-1:0]  btn;
    logic [TimeW-1:0] now;
    logic             typed;
    timer_res_t       want;
  } timer_item_t;

  localparam timer_res_t NoWant = '0;
  localparam int unsigned NumRows = 19;

  // cmd, button, now_ms, typed, {handled, remaining, minutes, seconds, pending}
  timer_item_t directed_rows [NumRows] = '{
    '{CMD_POLL,  3'd0, 32'd0,          1'b1, '{1'b1, 20'd0,    15'd0,  6'd0,  2'd0}},
    '{CMD_PRESS, 3'd0, 32'd0,          1'b1, '{1'b0, 20'd0,    15'd0,  6'd0,  2'd0}},
    '{CMD_PRESS, 3'd7, 32'd100,        1'b1, '{1'b0, 20'd0,    15'd0,  6'd0,  2'd0}},
    '{CMD_PRESS, 3'd1, 32'd1000,       1'b1, '{1'b1, 20'd0,    15'd0,  6'd0,  2'd1}},
    '{CMD_PRESS, 3'd1, 32'd1500,       1'b1, '{1'b1, 20'd0,    15'd0,  6'd0,  2'd2}},
    '{CMD_PRESS, 3'd1, 32'd1700,       1'b1, '{1'b1, 20'd0,    15'd0,  6'd0,  2'd3}},
    '{CMD_PRESS, 3'd1, 32'd1800,       1'b1, '{1'b1, 20'd0,    15'd0,  6'd0,  2'd3}},
    '{CMD_POLL,  3'd5, 32'd2000,       1'b0, NoWant},
    '{CMD_POLL,  3'd2, 32'd2300,       1'b0, NoWant},
    '{CMD_PRESS, 3'd1, 32'd2301,       1'b0, NoWant},
    '{CMD_POLL,  3'd0, 32'd3000,       1'b1, '{1'b1, 20'd59,   15'd0,  6'd59, 2'd0}},
    '{CMD_PRESS, 3'd1, 32'd10000,      1'b0, NoWant},
    '{CMD_PRESS, 3'd1, 32'd10400,      1'b0, NoWant},
    '{CMD_POLL,  3'd3, 32'd11000,      1'b1, '{1'b1, 20'd658,  15'd10, 6'd58, 2'd0}},
    '{CMD_PRESS, 3'd1, 32'hFFFF_FF00,  1'b0, NoWant},
    '{CMD_PRESS, 3'd1, 32'h0000_0010,  1'b1, '{1'b1, 20'd658,  15'd10, 6'd58, 2'd2}},
    '{CMD_POLL,  3'd6, 32'h0000_0300,  1'b0, NoWant},
    '{CMD_POLL,  3'd7, 32'h0000_0300,  1'b0, NoWant},
    '{CMD_PRESS, 3'd4, 32'h0000_0400,  1'b1, '{1'b0, 20'd1257, 15'd20, 6'd57, 2'd0}}
  };

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgW-1:0]     cfg_data_i    = '0;

  // timer model: registers and state
  logic [CfgW-1:0]  win_ms        = RstPressWindow;
  logic [CfgW-1:0]  period_ms     = RstTickPeriod;
  logic [CfgW-1:0]  add_single    = RstSingleAdd;
  logic [CfgW-1:0]  add_double    = RstDoubleAdd;
  logic [SecW-1:0]  secs_left     = '0;
  logic [CntW-1:0]  presses       = '0;
  logic [TimeW-1:0] last_press_ms = '0;
  logic [TimeW-1:0] last_tick_ms  = '0;

  timer_item_t stim_q [$];
  timer_item_t presented_q [$];
  timer_res_t  expected_q [$];
  logic [TimeW-1:0] clock_ms = '0;
  int errors = 0;

  int   seg_left  = 0;
  logic stall_seg = 1'b0;

  always #4 clk_i = ~clk_i;

  multi_press_countdown_timer_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // closing a group: three or more presses clear, else add with saturation
  function automatic void close_group();
    logic [SecW:0] sum;
    if (presses >= CntSat) begin
      secs_left = '0;
    end else if (presses != '0) begin
      sum = {1'b0, secs_left} + ((presses == 2'd1) ? add_single : add_double);
      secs_left = (sum > {1'b0, SecondsMax}) ? SecondsMax : sum[SecW-1:0];
    end
  endfunction

  function automatic timer_res_t timer_step(cmd_e cmd, logic [BtnW-1:0] btn,
                                            logic [TimeW-1:0] now);
    timer_res_t       r;
    logic [TimeW-1:0] since_press;
    logic [TimeW-1:0] since_tick;
    since_press = now - last_press_ms;
    since_tick  = now - last_tick_ms;
    r.handled   = 1'b1;
    if (cmd == CMD_PRESS) begin
      if (btn != CenterButton) begin
        r.handled = 1'b0;
      end else begin
        if (since_press <= win_ms) begin
          if (presses != CntSat) presses = presses + 1'b1;
        end else begin
          close_group();
          presses = 2'd1;
        end
        last_press_ms = now;
      end
    end else if (since_tick >= period_ms) begin
      // a finished group is only applied once its window has passed
      if (presses != '0 && since_press > win_ms) begin
        close_group();
        presses = '0;
      end
      if (secs_left != '0) secs_left = secs_left - 1'b1;
      last_tick_ms = now;
    end
    r.remaining = secs_left;
    r.mins      = MinW'(secs_left / 60);
    r.secs      = SecShW'(secs_left % 60);
    r.pend      = presses;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    timer_res_t  want;
    timer_item_t row;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_PRESS_WINDOW: win_ms     = cfg_data_i;
          REG_TICK_PERIOD:  period_ms  = cfg_data_i;
          REG_SINGLE_ADD:   add_single = cfg_data_i;
          REG_DOUBLE_ADD:   add_double = cfg_data_i;
          default: ;
        endcase
      end
      // results first, so a stray one never meets this cycle's expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          check_field("handled", 32'(want.handled), 32'(m_axis_tuser));
          check_field("remaining_seconds", 32'(want.remaining), 32'(m_axis_tdata[19:0]));
          check_field("minutes_shown", 32'(want.mins), 32'(m_axis_tdata[34:20]));
          check_field("seconds_shown", 32'(want.secs), 32'(m_axis_tdata[40:35]));
          check_field("pending_presses", 32'(want.pend), 32'(m_axis_tdata[42:41]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        row  = presented_q.pop_front();
        want = timer_step(cmd_e'(s_axis_tuser), s_axis_tdata[2:0], s_axis_tdata[34:3]);
        expected_q.push_back(row.typed ? row.want : want);
      end
    end
  end

  // result side: ready stretches of random length, sometimes with no stall between
  always @(negedge clk_i) begin
    if (seg_left == 0) begin
      if (stall_seg || $urandom_range(0, 3) == 0) begin
        stall_seg = 1'b0;
        seg_left  = $urandom_range(1, 40);
      end else begin
        stall_seg = 1'b1;
        seg_left  = $urandom_range(1, 12);
      end
    end
    m_axis_tready <= !stall_seg;
    seg_left--;
  end

  task automatic send_items();
    int          burst;
    int          gap;
    timer_item_t it;
    while (stim_q.size() != 0) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && stim_q.size() != 0) begin
        it = stim_q.pop_front();
        presented_q.push_back(it);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.cmd;
        s_axis_tdata  <= InDataW'({it.now, it.btn});
        do @(posedge clk_i); while (!s_axis_tready);
        @(negedge clk_i);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0 && stim_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic program_regs(logic [CfgW-1:0] win, logic [CfgW-1:0] tick,
                              logic [CfgW-1:0] single, logic [CfgW-1:0] dbl);
    cfg_reg_e        regs [4];
    logic [CfgW-1:0] vals [4];
    regs = '{REG_PRESS_WINDOW, REG_TICK_PERIOD, REG_SINGLE_ADD, REG_DOUBLE_ADD};
    vals = '{win, tick, single, dbl};
    for (int i = 0; i < 4; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0 || presented_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic void add_item(cmd_e cmd, logic [BtnW-1:0] btn);
    stim_q.push_back('{cmd, btn, clock_ms, 1'b0, NoWant});
  endfunction

  task automatic build_random(int n);
    int              pick;
    int              npress;
    logic [BtnW-1:0] b;
    while (stim_q.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // press group with its presses inside the window, then a few polls
        pick   = $urandom_range(0, 99);
        npress = (pick < 40) ? 1 : (pick < 75) ? 2 : (pick < 90) ? 3 : $urandom_range(4, 5);
        for (int k = 0; k < npress; k++) begin
          if (k == 0 && $urandom_range(0, 5) != 0) begin
            clock_ms = clock_ms + win_ms + 1 + $urandom_range(0, 2000);
          end else begin
            clock_ms = clock_ms + $urandom_range(0, win_ms);
          end
          add_item(CMD_PRESS, CenterButton);
          if ($urandom_range(0, 4) == 0) add_item(CMD_POLL, BtnW'($urandom_range(0, 7)));
        end
        repeat ($urandom_range(1, 4)) begin
          clock_ms = clock_ms + $urandom_range(0, 2 * period_ms);
          add_item(CMD_POLL, BtnW'($urandom_range(0, 7)));
        end
      end else if (pick < 90) begin
        clock_ms = clock_ms + $urandom_range(0, win_ms + 10);
        if ($urandom_range(0, 1) == 0) begin
          b = BtnW'($urandom_range(0, 6));
          if (b != '0) b = b + 1'b1;
          add_item(CMD_PRESS, b);
        end else begin
          add_item(CMD_POLL, BtnW'($urandom_range(0, 7)));
        end
      end else begin
        // jump anywhere in the 32-bit time range
        clock_ms = $urandom();
        add_item(cmd_e'($urandom_range(0, 1)), BtnW'($urandom_range(0, 7)));
      end
    end
  endtask

  task automatic run_phase(logic [CfgW-1:0] win, logic [CfgW-1:0] tick,
                           logic [CfgW-1:0] single, logic [CfgW-1:0] dbl, int n);
    program_regs(win, tick, single, dbl);
    build_random(n);
    send_items();
    drain();
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed_rows[i]) stim_q.push_back(directed_rows[i]);
    send_items();
    drain();
    clock_ms = 32'h0000_0400;
    build_random(80);
    send_items();
    drain();
    // narrowest window, fastest tick, largest additions: reaches saturation
    run_phase(16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 80);
    run_phase(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 60);
    // tiny additions and a fast tick so the count runs down to zero
    run_phase(16'd20, 16'd1, 16'd1, 16'd2, 80);
    run_phase(CfgW'($urandom_range(1, 2000)), CfgW'($urandom_range(1, 5000)),
              CfgW'($urandom_range(0, 65535)), CfgW'($urandom_range(0, 65535)), 100);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: multi_press_countdown_timer_top.f
sv/mpct_pkg.sv
sv/mpct_cfg.sv
sv/mpct_core.sv
sv/mpct_disp.sv
sv/multi_press_countdown_timer_top.sv
tb/sv/tb_multi_press_countdown_timer_top.sv
